// ===== design/spv_pkg.sv =====
package spv_pkg;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int SLOPE_W  = SAMPLE_W + 1;
  localparam int AREA_W   = COUNT_W + SAMPLE_W;
  localparam int CMP_W    = (AREA_W + 1 > 34) ? AREA_W + 1 : 34;
  localparam int DUR_W    = (COUNT_W + 1 > 16) ? COUNT_W + 1 : 16;
  localparam int MPS_W    = (SAMPLE_W > 16) ? SAMPLE_W : 16;

  // Queue sizes (powers of two, pointers wrap naturally)
  localparam int SQ_DEPTH = 4;
  localparam int SQ_PTR_W = $clog2(SQ_DEPTH);
  localparam int SQ_CNT_W = SQ_PTR_W + 1;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 34;

  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LIMIT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_RUN      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HALF_DUR  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HALF_DUR  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL_DUR = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HALF_AREA = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL_AREA = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK_SLOPE = 4'd7;

  typedef logic signed [SLOPE_W-1:0] slope_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [AREA_W-1:0]         area_t;
  typedef logic [CMP_W-1:0]          cmp_t;
  typedef logic [DUR_W-1:0]          dur_t;
  typedef logic [MPS_W-1:0]          mps_t;
  typedef logic [SAMPLE_W-1:0]       mag_t;

  localparam count_t FLAT_TOL = count_t'(4);

  // Phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PEAK   = 3'd1;
  localparam logic [2:0] PH_FLAT   = 3'd2;
  localparam logic [2:0] PH_VALLEY = 3'd3;
  localparam logic [2:0] PH_JUDGE  = 3'd4;

  typedef struct packed {
    logic [7:0]  slope_limit;
    logic [15:0] zero_run_limit;
    logic [7:0]  min_half_duration;
    logic [15:0] max_half_duration;
    logic [15:0] min_total_duration;
    logic [33:0] min_half_area;
    logic [33:0] min_total_area;
    logic [15:0] min_peak_slope;
  } spv_cfg_t;

  localparam spv_cfg_t CFG_RESET = '{
    slope_limit:        8'd5,
    zero_run_limit:     16'd20,
    min_half_duration:  8'd3,
    max_half_duration:  16'd64,
    min_total_duration: 16'd10,
    min_half_area:      34'd100,
    min_total_area:     34'd400,
    min_peak_slope:     16'd150
  };

  // One classified slope, front to back
  typedef struct packed {
    slope_t slope;
    logic   rising;
    logic   falling;
  } spv_slope_t;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

endpackage

// ===== design/spv_front.sv =====
module spv_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic signed [spv_pkg::SAMPLE_W-1:0] sample,
  input  logic [7:0]                          slope_limit,
  output spv_pkg::spv_slope_t                 entry
);

  logic signed [spv_pkg::SAMPLE_W-1:0] prev_r;
  logic signed [spv_pkg::SAMPLE_W-1:0] prev_nxt;
  spv_pkg::slope_t slope_raw;
  spv_pkg::slope_t slope;
  spv_pkg::slope_t lim;
  spv_pkg::slope_t neg_lim;

  always_comb begin
    slope_raw = spv_pkg::slope_t'(sample) - spv_pkg::slope_t'(prev_r);
    // drop single-LSB jitter
    if (slope_raw == spv_pkg::slope_t'(1) || slope_raw == spv_pkg::slope_t'(-1)) begin
      slope = '0;
    end else begin
      slope = slope_raw;
    end
    lim           = spv_pkg::slope_t'(slope_limit);
    neg_lim       = -lim;
    entry.slope   = slope;
    entry.rising  = (slope >= lim);
    entry.falling = (slope <= neg_lim);
    prev_nxt      = accept ? sample : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

// ===== design/spv_slope_q.sv =====
module spv_slope_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  spv_pkg::spv_slope_t wdata,
  input  logic                pop,
  output spv_pkg::spv_slope_t rdata,
  output logic                full,
  output logic                empty
);

  spv_pkg::spv_slope_t mem_r [spv_pkg::SQ_DEPTH];
  logic [spv_pkg::SQ_PTR_W-1:0] wr_r, wr_nxt;
  logic [spv_pkg::SQ_PTR_W-1:0] rd_r, rd_nxt;
  logic [spv_pkg::SQ_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full    = (cnt_r == spv_pkg::SQ_CNT_W'(spv_pkg::SQ_DEPTH));
    empty   = (cnt_r == '0);
    rdata   = mem_r[rd_r];
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// ===== design/spv_back.sv =====
module spv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  spv_pkg::spv_cfg_t   cfg,
  input  logic                q_empty,
  input  spv_pkg::spv_slope_t q_data,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic                out_step_detected
);

  // phase machine state
  logic [2:0]       phase_r, phase_nxt;
  spv_pkg::count_t  peak_time_r, peak_time_nxt;
  spv_pkg::count_t  valley_time_r, valley_time_nxt;
  spv_pkg::slope_t  peak_slope_r, peak_slope_nxt;
  spv_pkg::slope_t  valley_slope_r, valley_slope_nxt;
  spv_pkg::count_t  flat_count_r, flat_count_nxt;

  // judge second stage
  logic             s2_valid_r;
  logic             s2_judge_r, s2_judge_nxt;
  logic             s2_dur_ok_r, s2_dur_ok_nxt;
  spv_pkg::area_t   s2_area_peak_r, s2_area_peak_nxt;
  spv_pkg::area_t   s2_area_valley_r, s2_area_valley_nxt;

  // result queue
  logic             oq_mem_r [spv_pkg::OQ_DEPTH];
  logic [spv_pkg::OQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [spv_pkg::OQ_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;
  logic             oq_pop;

  spv_pkg::count_t  pt_inc, vt_inc, fc_inc;
  logic             flat;
  logic [spv_pkg::COUNT_W:0] total_time;
  spv_pkg::mag_t    pk_mag;
  spv_pkg::slope_t  vl_neg;
  spv_pkg::mag_t    vl_mag;
  spv_pkg::cmp_t    ap_c, av_c, sum_c;
  logic             step;

  always_comb begin
    q_pop  = !q_empty &&
             ((oq_cnt_r + spv_pkg::OQ_CNT_W'(s2_valid_r)) <
              spv_pkg::OQ_CNT_W'(spv_pkg::OQ_DEPTH));
    flat   = !q_data.rising && !q_data.falling;
    pt_inc = spv_pkg::sat_inc(peak_time_r);
    vt_inc = spv_pkg::sat_inc(valley_time_r);
    fc_inc = spv_pkg::sat_inc(flat_count_r);

    phase_nxt        = phase_r;
    peak_time_nxt    = peak_time_r;
    valley_time_nxt  = valley_time_r;
    peak_slope_nxt   = peak_slope_r;
    valley_slope_nxt = valley_slope_r;
    flat_count_nxt   = flat_count_r;

    if (q_pop) begin
      unique case (phase_r)
        spv_pkg::PH_IDLE: begin
          peak_time_nxt    = '0;
          valley_time_nxt  = '0;
          peak_slope_nxt   = '0;
          valley_slope_nxt = '0;
          flat_count_nxt   = '0;
          if (q_data.rising) begin
            phase_nxt = spv_pkg::PH_PEAK;
          end
        end
        spv_pkg::PH_PEAK: begin
          if (q_data.rising) begin
            peak_time_nxt = pt_inc;
            if (q_data.slope > peak_slope_r) begin
              peak_slope_nxt = q_data.slope;
            end
          end else if (flat) begin
            peak_time_nxt  = pt_inc;
            flat_count_nxt = fc_inc;
            if (fc_inc > spv_pkg::FLAT_TOL) begin
              phase_nxt = spv_pkg::PH_FLAT;
            end
          end else begin
            phase_nxt = spv_pkg::PH_VALLEY;
          end
        end
        spv_pkg::PH_FLAT: begin
          if (flat) begin
            flat_count_nxt = fc_inc;
            if (spv_pkg::dur_t'(fc_inc) > spv_pkg::dur_t'(cfg.zero_run_limit)) begin
              phase_nxt = spv_pkg::PH_IDLE;
            end
          end else if (q_data.rising) begin
            phase_nxt = spv_pkg::PH_IDLE;
          end else begin
            flat_count_nxt = '0;
            phase_nxt      = spv_pkg::PH_VALLEY;
          end
        end
        spv_pkg::PH_VALLEY: begin
          if (q_data.falling) begin
            valley_time_nxt = vt_inc;
            if (q_data.slope < valley_slope_r) begin
              valley_slope_nxt = q_data.slope;
            end
          end else if (flat) begin
            valley_time_nxt = vt_inc;
            flat_count_nxt  = fc_inc;
            if (fc_inc > spv_pkg::FLAT_TOL) begin
              phase_nxt = spv_pkg::PH_JUDGE;
            end
          end else begin
            phase_nxt = spv_pkg::PH_JUDGE;
          end
        end
        default: begin
          phase_nxt = spv_pkg::PH_IDLE;
        end
      endcase
    end

    // judge, first half: durations, slope and the two products
    total_time = {1'b0, peak_time_r} + {1'b0, valley_time_r};
    pk_mag     = peak_slope_r[spv_pkg::SAMPLE_W-1:0];
    vl_neg     = -valley_slope_r;
    vl_mag     = vl_neg[spv_pkg::SAMPLE_W-1:0];
    s2_judge_nxt  = (phase_r == spv_pkg::PH_JUDGE);
    s2_dur_ok_nxt =
      (spv_pkg::dur_t'(peak_time_r) > spv_pkg::dur_t'(cfg.min_half_duration)) &&
      (spv_pkg::dur_t'(valley_time_r) > spv_pkg::dur_t'(cfg.min_half_duration)) &&
      (spv_pkg::dur_t'(peak_time_r) < spv_pkg::dur_t'(cfg.max_half_duration)) &&
      (spv_pkg::dur_t'(valley_time_r) < spv_pkg::dur_t'(cfg.max_half_duration)) &&
      (spv_pkg::dur_t'(total_time) >= spv_pkg::dur_t'(cfg.min_total_duration)) &&
      (spv_pkg::mps_t'(pk_mag) >= spv_pkg::mps_t'(cfg.min_peak_slope));
    s2_area_peak_nxt   = spv_pkg::area_t'(peak_time_r) * spv_pkg::area_t'(pk_mag);
    s2_area_valley_nxt = spv_pkg::area_t'(valley_time_r) * spv_pkg::area_t'(vl_mag);

    // judge, second half: area thresholds
    ap_c  = spv_pkg::cmp_t'(s2_area_peak_r);
    av_c  = spv_pkg::cmp_t'(s2_area_valley_r);
    sum_c = ap_c + av_c;
    step  = s2_judge_r && s2_dur_ok_r &&
            (ap_c > spv_pkg::cmp_t'(cfg.min_half_area)) &&
            (av_c > spv_pkg::cmp_t'(cfg.min_half_area)) &&
            (sum_c > spv_pkg::cmp_t'(cfg.min_total_area));

    out_empty         = (oq_cnt_r == '0);
    out_step_detected = oq_mem_r[oq_rd_r];
    oq_pop            = out_pop && !out_empty;
    oq_cnt_nxt        = oq_cnt_r;
    if (s2_valid_r && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !s2_valid_r) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= spv_pkg::PH_IDLE;
      peak_time_r    <= '0;
      valley_time_r  <= '0;
      peak_slope_r   <= '0;
      valley_slope_r <= '0;
      flat_count_r   <= '0;
      s2_valid_r     <= 1'b0;
      oq_wr_r        <= '0;
      oq_rd_r        <= '0;
      oq_cnt_r       <= '0;
    end else begin
      phase_r        <= phase_nxt;
      peak_time_r    <= peak_time_nxt;
      valley_time_r  <= valley_time_nxt;
      peak_slope_r   <= peak_slope_nxt;
      valley_slope_r <= valley_slope_nxt;
      flat_count_r   <= flat_count_nxt;
      s2_valid_r     <= q_pop;
      if (s2_valid_r) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_judge_r       <= s2_judge_nxt;
      s2_dur_ok_r      <= s2_dur_ok_nxt;
      s2_area_peak_r   <= s2_area_peak_nxt;
      s2_area_valley_r <= s2_area_valley_nxt;
    end
    if (s2_valid_r) begin
      oq_mem_r[oq_wr_r] <= step;
    end
  end

endmodule

// ===== design/step_peak_valley_detector_top.sv =====
// Step detector on a stream of filtered acceleration magnitudes.
//
// Input channel: drive in_filtered_sample and raise in_push; the beat is taken
// at a rising edge where in_full is low. Every sample produces exactly one
// result beat, out_step_detected, set when the sample before it closed a
// valid step. Result channel: out_step_detected is valid while out_empty is
// low; raise out_pop to take it.
// Configuration: write thresholds through cfg_valid/cfg_index/cfg_data while
// no beat is in flight; cfg_ready is always high, unknown indexes are dropped.
// Throughput: one sample per cycle while the result queue has room. Path: the
// slope queue stores each sample's slope entry; popping it steps the phase
// machine and registers the two area products, and the area compare then
// writes the result queue.
// The front side stalls only when the four-entry slope queue fills; the back
// side stops when the four-entry result queue plus the beat in flight would
// overflow. So a receiver that holds off out_pop fills both queues and then
// raises in_full; nothing is lost.
// Reset (rst_n low, synchronous) empties both queues, returns the phase
// machine to idle with cleared counters, zeroes the stored previous sample and
// loads the default thresholds.
module step_peak_valley_detector_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [spv_pkg::SAMPLE_W-1:0]  in_filtered_sample,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_step_detected,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spv_pkg::CFG_DATA_W-1:0]       cfg_data
);

  spv_pkg::spv_cfg_t   cfg_r, cfg_nxt;
  spv_pkg::spv_slope_t front_entry;
  spv_pkg::spv_slope_t q_data;
  logic                in_accept;
  logic                q_empty;
  logic                q_pop;

  assign cfg_ready = 1'b1;
  assign in_accept = in_push && !in_full;

  // Register file: truncate the write data to the target width
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        spv_pkg::REG_SLOPE_LIMIT:    cfg_nxt.slope_limit        = cfg_data[7:0];
        spv_pkg::REG_ZERO_RUN:       cfg_nxt.zero_run_limit     = cfg_data[15:0];
        spv_pkg::REG_MIN_HALF_DUR:   cfg_nxt.min_half_duration  = cfg_data[7:0];
        spv_pkg::REG_MAX_HALF_DUR:   cfg_nxt.max_half_duration  = cfg_data[15:0];
        spv_pkg::REG_MIN_TOTAL_DUR:  cfg_nxt.min_total_duration = cfg_data[15:0];
        spv_pkg::REG_MIN_HALF_AREA:  cfg_nxt.min_half_area      = cfg_data[33:0];
        spv_pkg::REG_MIN_TOTAL_AREA: cfg_nxt.min_total_area     = cfg_data[33:0];
        spv_pkg::REG_MIN_PEAK_SLOPE: cfg_nxt.min_peak_slope     = cfg_data[15:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= spv_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: slope against previous sample, jitter drop, classify
  spv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .sample      (in_filtered_sample),
    .slope_limit (cfg_r.slope_limit),
    .entry       (front_entry)
  );

  // Decoupling queue between front and back
  spv_slope_q u_slope_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .wdata (front_entry),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (in_full),
    .empty (q_empty)
  );

  // Back: phase machine, judge pipeline and result queue
  spv_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_step_detected (out_step_detected)
  );

endmodule

// ===== design/spv_checker.sv =====
module spv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop
);

  localparam int CAP = spv_pkg::SQ_DEPTH + spv_pkg::OQ_DEPTH + 1;

  // beats taken in minus beats handed out
  logic [4:0] pend_r;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_push && !in_full;
  assign out_beat = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 5'(in_beat) - 5'(out_beat);
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pend_r != '0)
    else $error("result beat with no sample outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 5'(CAP))
    else $error("more beats in flight than storage allows");

  a_full_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> pend_r >= 5'(spv_pkg::SQ_DEPTH))
    else $error("full raised with slope queue not full");

endmodule

bind step_peak_valley_detector_top spv_checker u_spv_checker (.*);
